// ----- hdl/h264fu_pkg.sv -----
// Shared types and constants for the H.264 FU-A packetizer.
`default_nettype none

package h264fu_pkg;

	// One payload word as it leaves the packetizer.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
		logic       marker;
		logic       last;
	} res_t;

	// An input byte can cause at most three payload words.
	localparam int unsigned MaxRes = 3;
	localparam int unsigned ResCntW = 2;

	localparam logic [10:0] MaxFragReset = 11'd1398;
	localparam logic [10:0] MinFrag = 11'd2;

	// FU-A indicator and header fields.
	localparam logic [7:0] NriMask = 8'h60;
	localparam logic [7:0] TypeMask = 8'h1f;
	localparam logic [7:0] FuAType = 8'd28;
	localparam logic [7:0] FuStartBit = 8'h80;
	localparam logic [7:0] FuEndBit = 8'h40;

endpackage

`default_nettype wire

// ----- hdl/h264fu_engine.sv -----
// NAL framing state and the per-byte packetizing step.
`default_nettype none

module h264fu_engine #(
	parameter int unsigned LEN_W = 16,
	parameter int unsigned LEN_CAP = 65535
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        go,
	input  wire logic [7:0]                                  data_byte,
	input  wire logic [15:0]                                 nal_length,
	input  wire logic [10:0]                                 max_fragment,
	output h264fu_pkg::res_t [h264fu_pkg::MaxRes-1:0]        res,
	output logic [h264fu_pkg::ResCntW-1:0]                   res_cnt
);

	localparam int unsigned CmpW = 17;

	logic [LEN_W-1:0] nal_left_q, nal_left_d;
	logic [10:0]      frag_left_q, frag_left_d;
	logic [7:0]       hdr_q, hdr_d;
	logic             frag_q, frag_d;
	logic             first_q, first_d;

	logic [10:0]      m;
	logic [15:0]      len_nz;
	logic [CmpW-1:0]  len_sat;
	logic [CmpW-1:0]  m_x;
	logic [CmpW-1:0]  rem_x;
	logic [10:0]      size;
	logic [10:0]      frag_cur;
	logic [7:0]       fu_hdr;
	logic             fits;

	// Clamp the fragment size and the NAL length.
	always_comb begin
		m = (max_fragment < h264fu_pkg::MinFrag) ? h264fu_pkg::MinFrag : max_fragment;
		m_x = CmpW'(m);
		len_nz = (nal_length == 16'd0) ? 16'd1 : nal_length;
		len_sat = ({1'b0, len_nz} > CmpW'(LEN_CAP)) ? CmpW'(LEN_CAP) : {1'b0, len_nz};
		rem_x = CmpW'(nal_left_q);
		fits = (rem_x <= m_x);
	end

	// One step of the packetizer: next state and up to three words.
	always_comb begin
		nal_left_d = nal_left_q;
		frag_left_d = frag_left_q;
		hdr_d = hdr_q;
		frag_d = frag_q;
		first_d = first_q;
		res = '0;
		res_cnt = '0;
		size = '0;
		frag_cur = frag_left_q;
		fu_hdr = '0;
		if (nal_left_q == '0) begin
			// First byte of a new NAL.
			nal_left_d = LEN_W'(len_sat - CmpW'(1));
			frag_left_d = '0;
			if (len_sat <= m_x) begin
				frag_d = 1'b0;
				res[0] = '{out_byte: data_byte, packet_end: (len_sat == CmpW'(1)),
					marker: (len_sat == CmpW'(1)), last: 1'b1};
				res_cnt = 2'd1;
			end else begin
				frag_d = 1'b1;
				first_d = 1'b1;
				hdr_d = data_byte;
			end
		end else if (!frag_q) begin
			// Single-packet NAL: pass the byte through.
			nal_left_d = nal_left_q - LEN_W'(1);
			res[0] = '{out_byte: data_byte, packet_end: (nal_left_q == LEN_W'(1)),
				marker: (nal_left_q == LEN_W'(1)), last: 1'b1};
			res_cnt = 2'd1;
		end else begin
			if (frag_left_q == '0) begin
				// Open a fragment; keep start and end bits apart.
				size = fits ? 11'(nal_left_q) : m;
				if (first_q && fits && (nal_left_q > LEN_W'(1))) begin
					size = 11'(nal_left_q - LEN_W'(1));
				end
				fu_hdr = hdr_q & h264fu_pkg::TypeMask;
				if (first_q) begin
					fu_hdr = fu_hdr | h264fu_pkg::FuStartBit;
				end
				if (CmpW'(size) == rem_x) begin
					fu_hdr = fu_hdr | h264fu_pkg::FuEndBit;
				end
				res[0] = '{out_byte: (hdr_q & h264fu_pkg::NriMask) | h264fu_pkg::FuAType,
					packet_end: 1'b0, marker: 1'b0, last: 1'b0};
				res[1] = '{out_byte: fu_hdr, packet_end: 1'b0, marker: 1'b0, last: 1'b0};
				first_d = 1'b0;
				frag_cur = size;
			end
			nal_left_d = nal_left_q - LEN_W'(1);
			frag_left_d = frag_cur - 11'd1;
			if (frag_left_q == '0) begin
				res[2] = '{out_byte: data_byte, packet_end: (frag_cur == 11'd1),
					marker: (frag_cur == 11'd1) && (nal_left_q == LEN_W'(1)), last: 1'b1};
				res_cnt = 2'd3;
			end else begin
				res[0] = '{out_byte: data_byte, packet_end: (frag_cur == 11'd1),
					marker: (frag_cur == 11'd1) && (nal_left_q == LEN_W'(1)), last: 1'b1};
				res_cnt = 2'd1;
			end
			if (nal_left_q == LEN_W'(1)) begin
				frag_d = 1'b0;
				frag_left_d = '0;
			end
		end
	end

	// State registers advance on each consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nal_left_q <= '0;
			frag_left_q <= '0;
			hdr_q <= '0;
			frag_q <= 1'b0;
			first_q <= 1'b1;
		end else if (go) begin
			nal_left_q <= nal_left_d;
			frag_left_q <= frag_left_d;
			hdr_q <= hdr_d;
			frag_q <= frag_d;
			first_q <= first_d;
		end
	end

	// A fragment never has bytes left while the NAL has none.
	a_frag_in_nal: assert property (@(posedge clk) disable iff (!arst_n)
		(frag_left_q != '0) |-> (frag_q && (nal_left_q != '0)))
		else $error("open fragment outside a fragmented NAL");

	// Fragment count never exceeds the bytes left in the NAL.
	a_frag_le_nal: assert property (@(posedge clk) disable iff (!arst_n)
		CmpW'(frag_left_q) <= CmpW'(nal_left_q))
		else $error("fragment longer than the rest of the NAL");

	// Only one word is final for each step.
	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> ($countones({res[0].last, res[1].last, res[2].last}) <= 1))
		else $error("several final words in one step");

endmodule

`default_nettype wire

// ----- hdl/h264_fu_a_packetizer.sv -----
// Top level of the H.264 RTP FU-A packetizer: input stage, engine, result buffer.
//
//  channel | dir | accepted when               | word
//  s_*     | in  | s_tvalid & s_tready         | one NAL byte plus its length
//  m_*     | out | m_tvalid & m_tready         | one RTP payload byte
//  cfg_*   | in  | cfg_valid & cfg_ready       | max_fragment write
//
// A byte passes through the input register and the engine, then waits in
// a three-word result buffer. The output port drains one word per cycle while
// m_tready is high; a byte that opens a fragment yields three words, others
// one or none. The input register takes a new byte while results wait.
// Reset clears the NAL state (awaiting a new NAL) and loads max_fragment = 1398.
`default_nettype none

module h264_fu_a_packetizer #(
	parameter int unsigned NAL_LEN_MAX = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: [7:0] data_byte, [23:8] nal_length
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,
	// m_tdata: [7:0] out_byte; m_tlast: packet_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	// m_tuser: [0] marker, [1] last
	output logic [1:0]       m_tuser,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data
);

	localparam int unsigned LenCap = (NAL_LEN_MAX < 65535) ? NAL_LEN_MAX : 65535;
	localparam int unsigned LenW = $clog2(LenCap + 1);

	logic [10:0] max_frag_q;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic [15:0] len_s1;

	h264fu_pkg::res_t [h264fu_pkg::MaxRes-1:0] res;
	logic [h264fu_pkg::ResCntW-1:0]            res_cnt;
	h264fu_pkg::res_t                          buf_q [h264fu_pkg::MaxRes];
	logic [h264fu_pkg::ResCntW-1:0]            hd_q;
	logic [h264fu_pkg::ResCntW-1:0]            left_q;

	logic pop;
	logic move;
	h264fu_pkg::res_t head;

	// Handshake control.
	assign pop = m_tvalid && m_tready;
	assign move = v_s1 && ((left_q == '0) || ((left_q == 2'd1) && pop));
	assign s_tready = !v_s1 || move;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frag_q <= h264fu_pkg::MaxFragReset;
		end else if (cfg_valid && cfg_ready) begin
			max_frag_q <= cfg_data;
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			len_s1 <= s_tdata[23:8];
		end
	end

	h264fu_engine #(
		.LEN_W   (LenW),
		.LEN_CAP (LenCap)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (move),
		.data_byte    (byte_s1),
		.nal_length   (len_s1),
		.max_fragment (max_frag_q),
		.res          (res),
		.res_cnt      (res_cnt)
	);

	// Result buffer control: head index and words still to send.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_q <= '0;
			left_q <= '0;
		end else if (move) begin
			hd_q <= '0;
			left_q <= res_cnt;
		end else if (pop) begin
			hd_q <= hd_q + 2'd1;
			left_q <= left_q - 2'd1;
		end
	end

	// Result buffer payload.
	always_ff @(posedge clk) begin
		if (move) begin
			for (int i = 0; i < h264fu_pkg::MaxRes; i++) begin
				buf_q[i] <= res[i];
			end
		end
	end

	// Output port.
	assign head = buf_q[hd_q];
	assign m_tvalid = (left_q != '0);
	assign m_tdata = head.out_byte;
	assign m_tlast = head.packet_end;
	assign m_tuser = {head.last, head.marker};

	// The buffer never reads beyond its three words.
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, hd_q} + {1'b0, left_q}) <= 3'd3)
		else $error("result buffer index out of range");

	// The marker only comes with the end of a packet.
	a_marker_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("marker without packet end");

	// FU bytes are never the end of a packet.
	a_fu_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> !m_tlast)
		else $error("packet ends on an FU byte");

	// A held byte blocks the input until it moves into the buffer.
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !move) |-> !s_tready)
		else $error("input taken while the stage is full");

endmodule

`default_nettype wire

// ----- test/tb_h264_fu_a_packetizer.sv -----
// Self-checking testbench for the H.264 FU-A packetizer: predicted words against the output.
module tb_h264_fu_a_packetizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 1_000_000;
	localparam int unsigned DrainCycles = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// s_tdata: [7:0] data_byte, [23:8] nal_length
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// m_tdata: [7:0] out_byte
	logic [7:0]  m_tdata;
	logic        m_tlast;
	// m_tuser: [0] marker, [1] last
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;

	// Packetizer state as the testbench tracks it.
	logic [10:0] max_frag = h264fu_pkg::MaxFragReset;
	logic [15:0] nal_left = '0;
	logic [10:0] frag_left = '0;
	logic [7:0]  held_hdr = '0;
	logic        fragmenting = 1'b0;
	logic        first_frag = 1'b1;

	// Payload words predicted but not yet seen on the output.
	h264fu_pkg::res_t payload_q[$];

	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;

	h264_fu_a_packetizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("tb_h264_fu_a_packetizer: FAIL");
			$finish;
		end
	end

	function automatic void push_word(logic [7:0] b, logic pe, logic mk, logic ls);
		h264fu_pkg::res_t w;
		w.out_byte = b;
		w.packet_end = pe;
		w.marker = mk;
		w.last = ls;
		payload_q.push_back(w);
	endfunction

	// Predict the payload words that one accepted NAL byte produces.
	function automatic void packetize_byte(logic [7:0] b, logic [15:0] len_in);
		logic [10:0] m;
		logic [15:0] len;
		logic [15:0] rem;
		logic [15:0] size;
		logic [7:0]  hdr;
		logic        endf;
		m = (max_frag < h264fu_pkg::MinFrag) ? h264fu_pkg::MinFrag : max_frag;
		if (nal_left == '0) begin
			// First byte of a NAL: the length is sampled here, zero counts as one.
			len = (len_in == '0) ? 16'd1 : len_in;
			nal_left = len - 16'd1;
			frag_left = '0;
			if (len <= 16'(m)) begin
				fragmenting = 1'b0;
				endf = (nal_left == '0);
				push_word(b, endf, endf, 1'b1);
			end else begin
				// Too long for one packet: hold the header, no word goes out.
				fragmenting = 1'b1;
				first_frag = 1'b1;
				held_hdr = b;
			end
		end else if (!fragmenting) begin
			nal_left--;
			endf = (nal_left == '0);
			push_word(b, endf, endf, 1'b1);
		end else begin
			// Open a new fragment with the FU indicator and FU header.
			if (frag_left == '0) begin
				rem = nal_left;
				size = (rem <= 16'(m)) ? rem : 16'(m);
				// Keep start and end bits out of one FU header.
				if (first_frag && rem <= 16'(m) && rem > 16'd1)
					size = rem - 16'd1;
				hdr = held_hdr & h264fu_pkg::TypeMask;
				if (first_frag)
					hdr = hdr | h264fu_pkg::FuStartBit;
				if (size == rem)
					hdr = hdr | h264fu_pkg::FuEndBit;
				push_word((held_hdr & h264fu_pkg::NriMask) | h264fu_pkg::FuAType,
					1'b0, 1'b0, 1'b0);
				push_word(hdr, 1'b0, 1'b0, 1'b0);
				first_frag = 1'b0;
				frag_left = size[10:0];
			end
			nal_left--;
			frag_left--;
			endf = (frag_left == '0);
			push_word(b, endf, endf && (nal_left == '0), 1'b1);
			if (nal_left == '0) begin
				fragmenting = 1'b0;
				frag_left = '0;
			end
		end
	endfunction

	// Offer one NAL byte, wait for the handshake, then predict its words.
	task automatic send_nal_byte(input logic [7:0] b, input logic [15:0] len);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {len, b};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		packetize_byte(b, len);
		items_sent++;
	endtask

	// Send a whole NAL; the length field of the later bytes is noise.
	task automatic send_nal(input logic [7:0] hdr, input logic [15:0] len);
		int unsigned count;
		count = (len == '0) ? 1 : len;
		send_nal_byte(hdr, len);
		for (int unsigned i = 1; i < count; i++)
			send_nal_byte(8'($urandom), 16'($urandom));
	endtask

	// Stop sending and wait until every predicted word has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (payload_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write max_fragment while the block is idle.
	task automatic write_max_fragment(input logic [10:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		max_frag = value;
	endtask

	// Pass-through NALs at the reset setting, zero length among them.
	task automatic test_passthrough();
		send_nal(8'h00, 16'd1);
		send_nal(8'hff, 16'd0);
		send_nal(8'h65, 16'd3);
	endtask

	// Register values below the minimum, the single-FU split and exact division.
	task automatic test_tiny_fragments();
		write_max_fragment(11'd0);
		send_nal(8'hff, 16'd2);
		send_nal(8'h7c, 16'd3);
		write_max_fragment(11'd1);
		send_nal(8'h00, 16'd5);
		write_max_fragment(h264fu_pkg::MinFrag);
		send_nal(8'h9f, 16'd4);
	endtask

	// Random NALs with lengths clustered around the fragment boundaries.
	task automatic test_random_phase(input int unsigned m, input int unsigned src_pct,
			input int unsigned snk_pct, input int unsigned target);
		int unsigned start;
		int unsigned nals;
		logic [15:0] len;
		write_max_fragment(11'(m));
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		start = items_sent;
		nals = 0;
		while (items_sent - start < target) begin
			case ($urandom_range(5, 0))
				0: len = 16'($urandom_range(3, 0));
				1: len = 16'(m - 1 + $urandom_range(3, 0));
				2: len = 16'($urandom_range(3 * m, 1));
				3: len = 16'(2 * m + 1);
				4: len = 16'(m + 1);
				default: len = 16'($urandom_range(64, 1));
			endcase
			send_nal(8'($urandom), len);
			nals++;
			// Let the output run dry once so a NAL starts on an empty pipe.
			if (nals == 3)
				drain();
		end
	endtask

	// The largest register value and 1498, with short NALs passing straight through.
	task automatic test_long_nal();
		write_max_fragment(11'h7ff);
		send_nal(8'($urandom), 16'd32);
		write_max_fragment(11'd1498);
		send_nal(8'($urandom), 16'd8);
	endtask

	// Take each output word, compare it with the oldest prediction, then pick tready.
	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_words
		h264fu_pkg::res_t got;
		h264fu_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.out_byte = m_tdata;
			got.packet_end = m_tlast;
			got.marker = m_tuser[0];
			got.last = m_tuser[1];
			if (payload_q.size() == 0) begin
				errors++;
				$display("%0t: word with nothing expected, actual %h", $time, got);
			end else begin
				want = payload_q.pop_front();
				check_field("out_byte", want.out_byte, got.out_byte);
				check_field("packet_end", 8'(want.packet_end), 8'(got.packet_end));
				check_field("marker", 8'(want.marker), 8'(got.marker));
				check_field("last", 8'(want.last), 8'(got.last));
			end
		end
		m_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct = 33;
		snk_idle_pct = 86;
		test_passthrough();
		test_tiny_fragments();
		test_random_phase(16, 33, 86, 80);
		test_random_phase($urandom_range(40, 3), 86, 33, 80);
		test_random_phase(5, 0, 0, 80);
		test_long_nal();
		drain();
		if (errors == 0)
			$display("tb_h264_fu_a_packetizer: PASS");
		else
			$display("tb_h264_fu_a_packetizer: FAIL");
		$finish;
	end

endmodule
